FILE: src/lms_pkg.sv
// Shared types and fixed-point constants of the LMS adaptive FIR predictor.
package lms_pkg;

    localparam int SAMPLE_W = 16;   // Q1.15 samples and error
    localparam int WEIGHT_W = 32;   // Q4.28 weights
    localparam int ACC_W    = 48;   // Q5.43 accumulator
    localparam int PROD_W   = 48;   // shared multiplier result
    localparam int MU_W     = 15;   // Q0.15 step size, unsigned
    localparam int MUE_W    = 32;   // step size times error

    localparam logic [MU_W-1:0] STEP_SIZE_RESET = 15'd6554;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;     // write zero to both stores at the tap index
        logic load_x;     // take the new sample into the delay line, clear the accumulator
        logic fir_rd;     // read one tap for the filter pass
        logic upd_rd;     // read one tap for the weight update pass
        logic err_calc;   // form the saturated error from the accumulator
        logic out_go;     // form mu times error and hand the error to the output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // the output register can take a result this cycle
    } t_stat;

endpackage

FILE: src/lms_adaptive_fir.sv
// Top level of the LMS adaptive FIR predictor: controller and datapath.
//
// Input channel: a sample transfer takes place at a rising edge with i_in_valid high and
// o_in_stall low. Each sample enters a delay line of NUM_TAPS taps, newest first, and one
// error result follows on the output channel (o_out_valid, i_out_stall, o_error_out).
// One shared 32 by 16 multiply-accumulate walks the taps twice per sample: once to form
// the filter output, once to update the weights. An item therefore occupies the block from
// its transfer until the end of the update pass, and only then can the next sample be taken;
// the error reaches the output register after the filter pass, before the update pass.
// The error sits in an output register, so a receiver that stalls does not hold up the
// weight update; the block only waits if a second error is ready while the first has
// still not been taken.
// Reset is synchronous and active low. After reset the block sweeps both tap stores to
// zero, one tap per cycle; o_in_stall stays high meanwhile.
// The step size register reloads its default of about 0.2 and may be written at any time
// the block is idle, including during the sweep.
module lms_adaptive_fir
    import lms_pkg::*;
#(
    parameter int NUM_TAPS = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_error_out,
    input  logic                       i_step_size_we,
    input  logic [MU_W-1:0]            i_step_size
);

    t_cmd                        s_cmd;
    t_stat                       s_stat;
    logic [$clog2(NUM_TAPS)-1:0] s_idx;

    // The controller sequences the passes and owns the tap counter.
    lms_ctrl #(.NUM_TAPS(NUM_TAPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd),
        .o_idx      (s_idx)
    );

    // The datapath holds the stores, the arithmetic and the output register.
    lms_dpath #(.NUM_TAPS(NUM_TAPS)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .i_idx          (s_idx),
        .i_sample_in    (i_sample_in),
        .i_step_size_we (i_step_size_we),
        .i_step_size    (i_step_size),
        .i_out_stall    (i_out_stall),
        .o_stat         (s_stat),
        .o_out_valid    (o_out_valid),
        .o_error_out    (o_error_out)
    );

endmodule

FILE: src/lms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lms_ctrl.sv
// Controller state machine: clearing sweep, filter pass, error, output and weight update pass.
module lms_ctrl
    import lms_pkg::*;
#(
    parameter int NUM_TAPS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  t_stat                       i_stat,
    output t_cmd                        o_cmd,
    output logic [$clog2(NUM_TAPS)-1:0] o_idx
);

    localparam int TAP_W = $clog2(NUM_TAPS);
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FIR   = 3'd2;
    localparam logic [2:0] ST_DRN1  = 3'd3;
    localparam logic [2:0] ST_DRN2  = 3'd4;
    localparam logic [2:0] ST_ERR   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam logic [2:0] ST_UPD   = 3'd7;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [TAP_W-1:0] r_idx;
    logic [TAP_W-1:0] n_idx;
    logic             s_last;

    assign s_last = (r_idx == LAST_TAP);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (s_last) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_state      = ST_FIR;
                    n_idx        = '0;
                end
            end
            ST_FIR: begin
                o_cmd.fir_rd = 1'b1;
                if (s_last) begin
                    n_state = ST_DRN1;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRN1: n_state = ST_DRN2;
            ST_DRN2: n_state = ST_ERR;
            ST_ERR: begin
                o_cmd.err_calc = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.out_go = 1'b1;
                if (i_stat.out_free) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.upd_rd = 1'b1;
                if (s_last) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_idx      = r_idx;

endmodule

FILE: src/lms_dpath.sv
// Datapath: tap stores, shared multiplier, accumulator, error, weight update and output register.
module lms_dpath
    import lms_pkg::*;
#(
    parameter int NUM_TAPS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [$clog2(NUM_TAPS)-1:0] i_idx,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    input  logic                        i_step_size_we,
    input  logic [MU_W-1:0]             i_step_size,
    input  logic                        i_out_stall,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    output logic signed [SAMPLE_W-1:0]  o_error_out
);

    localparam int TAP_W = $clog2(NUM_TAPS);
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);
    localparam logic [TAP_W:0]   TAP_CNT  = (TAP_W + 1)'(NUM_TAPS);

    // Control registers.
    logic [MU_W-1:0]  r_step;
    logic [TAP_W-1:0] r_head;
    logic             r_v1, r_m1, r_v2, r_m2;
    logic             r_out_valid;

    // Payload registers.
    logic [TAP_W-1:0]           r_idx1, r_idx2;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [WEIGHT_W-1:0] r_w2;
    logic signed [SAMPLE_W-1:0] r_err;
    logic signed [MUE_W-1:0]    r_mue;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [TAP_W-1:0]           s_head_dec;
    logic [TAP_W:0]             s_addr_sum;
    logic [TAP_W-1:0]           s_samp_raddr;
    logic                       s_samp_we, s_wgt_we;
    logic [TAP_W-1:0]           s_samp_waddr, s_wgt_waddr;
    logic [SAMPLE_W-1:0]        s_samp_wdata, s_samp_rdata;
    logic [WEIGHT_W-1:0]        s_wgt_wdata, s_wgt_rdata;
    logic signed [WEIGHT_W-1:0] s_mult_a;
    logic signed [PROD_W-1:0]   s_prod;
    logic signed [ACC_W:0]      s_acc_sum;
    logic signed [ACC_W-1:0]    s_acc_sat;
    logic signed [PROD_W-1:0]   s_rnd;
    logic signed [WEIGHT_W-1:0] s_delta;
    logic signed [WEIGHT_W:0]   s_wsum;
    logic signed [WEIGHT_W-1:0] s_wnew;
    logic signed [ACC_W:0]      s_xfull;
    logic signed [ACC_W:0]      s_efull;
    logic signed [20:0]         s_eq;
    logic signed [SAMPLE_W-1:0] s_esat;
    logic signed [MUE_W-1:0]    s_mue;
    logic                       s_out_free;

    // The delay line is a circular buffer: tap i lives at head + i, wrapped.
    assign s_head_dec   = (r_head == '0) ? LAST_TAP : (r_head - 1'b1);
    assign s_addr_sum   = {1'b0, r_head} + {1'b0, i_idx};
    assign s_samp_raddr = (s_addr_sum >= TAP_CNT) ? TAP_W'(s_addr_sum - TAP_CNT)
                                                  : s_addr_sum[TAP_W-1:0];

    assign s_samp_we    = i_cmd.clr_wr | i_cmd.load_x;
    assign s_samp_waddr = i_cmd.clr_wr ? i_idx : s_head_dec;
    assign s_samp_wdata = i_cmd.clr_wr ? '0 : i_sample_in;

    assign s_wgt_we     = i_cmd.clr_wr | (r_v2 & r_m2);
    assign s_wgt_waddr  = i_cmd.clr_wr ? i_idx : r_idx2;
    assign s_wgt_wdata  = i_cmd.clr_wr ? '0 : s_wnew;

    lms_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_samp_ram (
        .i_clk   (i_clk),
        .i_we    (s_samp_we),
        .i_waddr (s_samp_waddr),
        .i_wdata (s_samp_wdata),
        .i_raddr (s_samp_raddr),
        .o_rdata (s_samp_rdata)
    );

    lms_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_TAPS)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (s_wgt_we),
        .i_waddr (s_wgt_waddr),
        .i_wdata (s_wgt_wdata),
        .i_raddr (i_idx),
        .o_rdata (s_wgt_rdata)
    );

    // One 32 by 16 multiplier serves both passes.
    assign s_mult_a = r_m1 ? r_mue : $signed(s_wgt_rdata);
    assign s_prod   = PROD_W'(s_mult_a) * PROD_W'($signed(s_samp_rdata));

    // Accumulate with saturation to 48 bits.
    assign s_acc_sum = {r_acc[ACC_W-1], r_acc} + {r_prod[PROD_W-1], r_prod};
    always_comb begin
        if (s_acc_sum[ACC_W] != s_acc_sum[ACC_W-1]) begin
            s_acc_sat = s_acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            s_acc_sat = s_acc_sum[ACC_W-1:0];
        end
    end

    // Weight step: (mu*e*x*2 + 2^16) >> 17 equals (mu*e*x + 2^15) >> 16.
    assign s_rnd   = r_prod + 48'sd32768;
    assign s_delta = s_rnd[47:16];
    assign s_wsum  = {r_w2[WEIGHT_W-1], r_w2} + {s_delta[WEIGHT_W-1], s_delta};
    always_comb begin
        if (s_wsum[WEIGHT_W] != s_wsum[WEIGHT_W-1]) begin
            s_wnew = s_wsum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                      : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            s_wnew = s_wsum[WEIGHT_W-1:0];
        end
    end

    // Error in Q.43, rounded to Q1.15 and saturated.
    assign s_xfull = {{5{r_x[SAMPLE_W-1]}}, r_x, 28'b0};
    assign s_efull = s_xfull - {r_acc[ACC_W-1], r_acc} + 49'sd134217728;
    assign s_eq    = s_efull[48:28];
    always_comb begin
        if (s_eq[20:15] != {6{s_eq[20]}}) begin
            s_esat = s_eq[20] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            s_esat = s_eq[15:0];
        end
    end

    assign s_mue      = $signed({17'b0, r_step}) * MUE_W'(r_err);
    assign s_out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_SIZE_RESET;
            r_head      <= '0;
            r_v1        <= 1'b0;
            r_m1        <= 1'b0;
            r_v2        <= 1'b0;
            r_m2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step_size_we) begin
                r_step <= i_step_size;
            end
            if (i_cmd.load_x) begin
                r_head <= s_head_dec;
            end
            r_v1 <= i_cmd.fir_rd | i_cmd.upd_rd;
            r_m1 <= i_cmd.upd_rd;
            r_v2 <= r_v1;
            r_m2 <= r_m1;
            if (i_cmd.out_go && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_prod <= s_prod;
        r_w2   <= $signed(s_wgt_rdata);
        if (i_cmd.load_x) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.load_x) begin
            r_acc <= '0;
        end else if (r_v2 && !r_m2) begin
            r_acc <= s_acc_sat;
        end
        if (i_cmd.err_calc) begin
            r_err <= s_esat;
        end
        if (i_cmd.out_go) begin
            r_mue <= s_mue;
        end
        if (i_cmd.out_go && s_out_free) begin
            r_out <= r_err;
        end
    end

    assign o_stat.out_free = s_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_error_out     = r_out;

endmodule

FILE: src/lms_checker.sv
// Port-level checks of the LMS adaptive FIR predictor and their binding to the top level.
module lms_checker
    import lms_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_error_out
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_error_out))
        else $error("stalled result changed");

    // The block works on one sample at a time.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second sample taken while busy");

    // A new result only appears while a sample is being processed.
    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("result appeared while idle");

endmodule

bind lms_adaptive_fir lms_checker u_lms_checker (.*);
